### hdl/rxfaf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rxfaf_pkg;

    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned POS_W       = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_OWN_NETWORK_ID = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OWN_NODE_ID    = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BROADCAST_ID   = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_ENABLE  = 8'd3;

    localparam logic [POS_W-1:0] POS_NETWORK     = 3'd0;
    localparam logic [POS_W-1:0] POS_DESTINATION = 3'd1;
    localparam logic [POS_W-1:0] POS_SOURCE      = 3'd2;
    localparam logic [POS_W-1:0] POS_LENGTH      = 3'd3;
    localparam logic [POS_W-1:0] POS_PAYLOAD     = 3'd4;

    localparam logic [7:0] FIELD_MISSING = 8'hFF;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic       is_payload;
        logic [7:0] payload_byte;
        logic       frame_end;
        logic       frame_accepted;
        logic       length_mismatch;
        logic       address_mismatch;
        logic [7:0] frame_network;
        logic [7:0] frame_destination;
        logic [7:0] frame_source;
    } t_out_item;

    typedef struct packed {
        logic [7:0] own_network_id;
        logic [7:0] own_node_id;
        logic [7:0] broadcast_id;
        logic       filter_enable;
    } t_cfg;

    typedef struct packed {
        logic accepted;
        logic length_mismatch;
        logic address_mismatch;
    } t_verdict;

endpackage

`default_nettype wire

### hdl/rx_frame_address_filter.sv
`timescale 1ns / 1ps
`default_nettype none

// Receive frame filter: one frame byte per input transfer, one result per byte.
// Bytes 0..3 are network id, destination id, source id and declared length;
// later bytes come out flagged as payload and are counted modulo 256. The byte
// carrying last_byte also carries the verdict and the captured header ids
// (missing header bytes read as 255). A byte is taken every cycle while the
// output register is empty or being drained, and its result is held in the
// single output register, valid in the cycle after the input transfer.
// Configuration writes (index 0..3, others ignored) are expected only while
// no frame byte is in flight.

module rx_frame_address_filter (
    input  var logic                                  i_clk,
    input  var logic                                  i_rst_n,
    input  var logic                                  i_in_valid,
    output var logic                                  o_in_ready,
    input  var rxfaf_pkg::t_in_item                   i_in,
    output var logic                                  o_out_valid,
    input  var logic                                  i_out_ready,
    output var rxfaf_pkg::t_out_item                  o_out,
    input  var logic                                  i_cfg_valid,
    output var logic                                  o_cfg_ready,
    input  var logic [rxfaf_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  var logic [7:0]                            i_cfg_data
);

    rxfaf_pkg::t_cfg      r_cfg;
    logic [rxfaf_pkg::POS_W-1:0] r_pos, n_pos;
    logic [7:0]           r_net, n_net;
    logic [7:0]           r_dst, n_dst;
    logic [7:0]           r_src, n_src;
    logic [7:0]           r_len, n_len;
    logic [7:0]           r_cnt, n_cnt;
    logic                 r_out_valid;
    rxfaf_pkg::t_out_item r_out, n_out;

    logic                 w_accept;
    logic                 w_payload;
    rxfaf_pkg::t_verdict  w_verdict;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_network_id <= 8'd0;
            r_cfg.own_node_id    <= 8'd0;
            r_cfg.broadcast_id   <= 8'hFF;
            r_cfg.filter_enable  <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rxfaf_pkg::REG_OWN_NETWORK_ID: r_cfg.own_network_id <= i_cfg_data;
                rxfaf_pkg::REG_OWN_NODE_ID:    r_cfg.own_node_id    <= i_cfg_data;
                rxfaf_pkg::REG_BROADCAST_ID:   r_cfg.broadcast_id   <= i_cfg_data;
                rxfaf_pkg::REG_FILTER_ENABLE:  r_cfg.filter_enable  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // header capture and payload count, with the current byte folded in
    always_comb begin
        n_net     = r_net;
        n_dst     = r_dst;
        n_src     = r_src;
        n_len     = r_len;
        n_cnt     = r_cnt;
        n_pos     = r_pos;
        w_payload = 1'b0;
        case (r_pos)
            rxfaf_pkg::POS_NETWORK:     n_net = i_in.rx_byte;
            rxfaf_pkg::POS_DESTINATION: n_dst = i_in.rx_byte;
            rxfaf_pkg::POS_SOURCE:      n_src = i_in.rx_byte;
            rxfaf_pkg::POS_LENGTH:      n_len = i_in.rx_byte;
            default: begin
                w_payload = 1'b1;
                n_cnt     = r_cnt + 8'd1;
            end
        endcase
        if (r_pos < rxfaf_pkg::POS_PAYLOAD) begin
            n_pos = r_pos + 3'd1;
        end
    end

    rxfaf_check u_check (
        .i_cfg             (r_cfg),
        .i_network         (n_net),
        .i_destination     (n_dst),
        .i_declared_length (n_len),
        .i_payload_count   (n_cnt),
        .o_verdict         (w_verdict)
    );

    always_comb begin
        n_out              = '0;
        n_out.is_payload   = w_payload;
        n_out.payload_byte = w_payload ? i_in.rx_byte : 8'd0;
        if (i_in.last_byte) begin
            n_out.frame_end         = 1'b1;
            n_out.frame_accepted    = w_verdict.accepted;
            n_out.length_mismatch   = w_verdict.length_mismatch;
            n_out.address_mismatch  = w_verdict.address_mismatch;
            n_out.frame_network     = n_net;
            n_out.frame_destination = n_dst;
            n_out.frame_source      = n_src;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= rxfaf_pkg::POS_NETWORK;
            r_net       <= rxfaf_pkg::FIELD_MISSING;
            r_dst       <= rxfaf_pkg::FIELD_MISSING;
            r_src       <= rxfaf_pkg::FIELD_MISSING;
            r_len       <= rxfaf_pkg::FIELD_MISSING;
            r_cnt       <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_out_valid <= 1'b1;
                if (i_in.last_byte) begin
                    r_pos <= rxfaf_pkg::POS_NETWORK;
                    r_net <= rxfaf_pkg::FIELD_MISSING;
                    r_dst <= rxfaf_pkg::FIELD_MISSING;
                    r_src <= rxfaf_pkg::FIELD_MISSING;
                    r_len <= rxfaf_pkg::FIELD_MISSING;
                    r_cnt <= 8'd0;
                end else begin
                    r_pos <= n_pos;
                    r_net <= n_net;
                    r_dst <= n_dst;
                    r_src <= n_src;
                    r_len <= n_len;
                    r_cnt <= n_cnt;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

### hdl/rxfaf_check.sv
`timescale 1ns / 1ps
`default_nettype none

module rxfaf_check (
    input  var rxfaf_pkg::t_cfg     i_cfg,
    input  var logic [7:0]          i_network,
    input  var logic [7:0]          i_destination,
    input  var logic [7:0]          i_declared_length,
    input  var logic [7:0]          i_payload_count,
    output var rxfaf_pkg::t_verdict o_verdict
);

    logic w_len_bad;
    logic w_net_ok;
    logic w_dst_ok;
    logic w_addr_bad;

    assign w_len_bad  = i_payload_count != i_declared_length;
    assign w_net_ok   = (i_network == i_cfg.own_network_id)
                        || (i_network == i_cfg.broadcast_id);
    assign w_dst_ok   = (i_destination == i_cfg.own_node_id)
                        || (i_destination == i_cfg.broadcast_id);
    assign w_addr_bad = !(w_net_ok && w_dst_ok);

    assign o_verdict.length_mismatch  = w_len_bad;
    assign o_verdict.address_mismatch = w_addr_bad;
    assign o_verdict.accepted         = !i_cfg.filter_enable || (!w_len_bad && !w_addr_bad);

endmodule

`default_nettype wire

### tb/rx_frame_address_filter_tb.sv
`timescale 1ns / 1ps

module rx_frame_address_filter_tb;

    localparam int RANDOM_ITEMS = 200;
    localparam int PHASE_ITEMS  = 30;
    localparam int CFG_W        = rxfaf_pkg::CFG_INDEX_W;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_ready;
    rxfaf_pkg::t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    rxfaf_pkg::t_out_item out_item;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [CFG_W-1:0] cfg_index;
    logic [7:0] cfg_data;

    // filter model: header capture and payload count
    logic [rxfaf_pkg::POS_W-1:0] fr_pos;
    logic [7:0] fr_net;
    logic [7:0] fr_dst;
    logic [7:0] fr_src;
    logic [7:0] fr_len;
    logic [7:0] fr_count;

    logic [7:0] cfg_own_net;
    logic [7:0] cfg_own_node;
    logic [7:0] cfg_bcast;
    logic       cfg_filter_en;

    rxfaf_pkg::t_out_item pending_results[$];
    logic [7:0] frame_bytes[$];
    int         error_count;
    int         bytes_sent;
    bit         quiet_in;
    bit         quiet_out;

    rx_frame_address_filter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int draw_wait(bit quiet);
        return quiet ? 0 : int'($urandom_range(0, 19));
    endfunction

    function automatic void clear_frame();
        fr_pos   = rxfaf_pkg::POS_NETWORK;
        fr_net   = rxfaf_pkg::FIELD_MISSING;
        fr_dst   = rxfaf_pkg::FIELD_MISSING;
        fr_src   = rxfaf_pkg::FIELD_MISSING;
        fr_len   = rxfaf_pkg::FIELD_MISSING;
        fr_count = 8'd0;
    endfunction

    function automatic rxfaf_pkg::t_out_item filter_byte(rxfaf_pkg::t_in_item it);
        rxfaf_pkg::t_out_item r;
        logic len_bad;
        logic addr_bad;
        r = '0;
        case (fr_pos)
            rxfaf_pkg::POS_NETWORK:     fr_net = it.rx_byte;
            rxfaf_pkg::POS_DESTINATION: fr_dst = it.rx_byte;
            rxfaf_pkg::POS_SOURCE:      fr_src = it.rx_byte;
            rxfaf_pkg::POS_LENGTH:      fr_len = it.rx_byte;
            default: begin
                r.is_payload   = 1'b1;
                r.payload_byte = it.rx_byte;
                fr_count       = fr_count + 8'd1;
            end
        endcase
        if (fr_pos < rxfaf_pkg::POS_PAYLOAD) begin
            fr_pos = fr_pos + 3'd1;
        end
        if (it.last_byte) begin
            len_bad  = (fr_count != fr_len);
            addr_bad = !(((fr_net == cfg_own_net) || (fr_net == cfg_bcast)) &&
                         ((fr_dst == cfg_own_node) || (fr_dst == cfg_bcast)));
            r.frame_end         = 1'b1;
            r.frame_accepted    = !cfg_filter_en || (!len_bad && !addr_bad);
            r.length_mismatch   = len_bad;
            r.address_mismatch  = addr_bad;
            r.frame_network     = fr_net;
            r.frame_destination = fr_dst;
            r.frame_source      = fr_src;
            clear_frame();
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_monitor
        rxfaf_pkg::t_out_item want;
        if (!i_rst_n) begin
            cfg_own_net   = 8'd0;
            cfg_own_node  = 8'd0;
            cfg_bcast     = 8'hFF;
            cfg_filter_en = 1'b1;
            clear_frame();
            pending_results.delete();
        end else begin
            if (in_valid && in_ready) begin
                pending_results.push_back(filter_byte(in_item));
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    rxfaf_pkg::REG_OWN_NETWORK_ID: cfg_own_net   = cfg_data;
                    rxfaf_pkg::REG_OWN_NODE_ID:    cfg_own_node  = cfg_data;
                    rxfaf_pkg::REG_BROADCAST_ID:   cfg_bcast     = cfg_data;
                    rxfaf_pkg::REG_FILTER_ENABLE:  cfg_filter_en = cfg_data[0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t ns: unexpected result transfer, actual %0h", $time, out_item);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("is_payload", 8'(want.is_payload), 8'(out_item.is_payload));
                    check_field("payload_byte", want.payload_byte, out_item.payload_byte);
                    check_field("frame_end", 8'(want.frame_end), 8'(out_item.frame_end));
                    check_field("frame_accepted", 8'(want.frame_accepted),
                                8'(out_item.frame_accepted));
                    check_field("length_mismatch", 8'(want.length_mismatch),
                                8'(out_item.length_mismatch));
                    check_field("address_mismatch", 8'(want.address_mismatch),
                                8'(out_item.address_mismatch));
                    check_field("frame_network", want.frame_network, out_item.frame_network);
                    check_field("frame_destination", want.frame_destination,
                                out_item.frame_destination);
                    check_field("frame_source", want.frame_source, out_item.frame_source);
                end
            end
        end
    end

    // result side: random stall before each transfer
    initial begin : result_sink
        int stall;
        forever begin
            stall = draw_wait(quiet_out);
            @(negedge i_clk);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!(out_valid && out_ready));
        end
    end

    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        gap = draw_wait(quiet_in);
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_item  <= rxfaf_pkg::t_in_item'{b, last};
        in_valid <= 1'b1;
        do @(posedge i_clk); while (!in_ready);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++) begin
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        end
        frame_bytes.delete();
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_W-1:0] idx, logic [7:0] data);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all_regs(logic [7:0] net, logic [7:0] node, logic [7:0] bcast,
                                  logic en);
        write_reg(rxfaf_pkg::REG_OWN_NETWORK_ID, net);
        write_reg(rxfaf_pkg::REG_OWN_NODE_ID, node);
        write_reg(rxfaf_pkg::REG_BROADCAST_ID, bcast);
        write_reg(rxfaf_pkg::REG_FILTER_ENABLE, {7'($urandom), en});
    endtask

    task automatic test_default_config();
        frame_bytes = '{8'h00, 8'h00, 8'h05, 8'h02, 8'hAA, 8'h55};
        send_frame();
        frame_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'h00};
        send_frame();
        wait_drain();
    endtask

    task automatic test_short_frames();
        frame_bytes = '{8'h00};
        send_frame();
        frame_bytes = '{8'h00, 8'h7F};
        send_frame();
        frame_bytes = '{8'hFF, 8'h00, 8'h80};
        send_frame();
        wait_drain();
    endtask

    task automatic test_both_mismatch();
        frame_bytes = '{8'h12, 8'h34, 8'h56, 8'h05, 8'hFF};
        send_frame();
        wait_drain();
    endtask

    task automatic test_filter_disabled();
        write_reg(rxfaf_pkg::REG_FILTER_ENABLE, 8'h00);
        frame_bytes = '{8'h12, 8'h34, 8'h01, 8'h09, 8'h3C};
        send_frame();
        frame_bytes = '{8'h01};
        send_frame();
        wait_drain();
        write_reg(rxfaf_pkg::REG_FILTER_ENABLE, 8'h01);
    endtask

    // payload count wraps modulo 256
    task automatic test_long_payload();
        quiet_in = 1'b1;
        frame_bytes = '{8'h00, 8'hFF, 8'h21, 8'd44};
        repeat (300) frame_bytes.push_back(8'($urandom));
        send_frame();
        quiet_in = 1'b0;
        frame_bytes = '{8'hFF, 8'h00, 8'h42, 8'h00};
        repeat (256) frame_bytes.push_back(8'($urandom));
        send_frame();
        frame_bytes = '{8'h00, 8'h00, 8'h43, 8'hFF};
        repeat (255) frame_bytes.push_back(8'($urandom));
        send_frame();
        wait_drain();
    endtask

    function automatic logic [7:0] pick_id(logic [7:0] own);
        case ($urandom_range(0, 3))
            0, 1:    return own;
            2:       return cfg_bcast;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic random_frame();
        int kind;
        int n_pay;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom));
        end else if (kind == 1) begin
            repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom));
        end else begin
            n_pay = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40)
                                                 : $urandom_range(0, 12);
            frame_bytes.push_back(pick_id(cfg_own_net));
            frame_bytes.push_back(pick_id(cfg_own_node));
            frame_bytes.push_back(8'($urandom));
            frame_bytes.push_back(($urandom_range(0, 3) != 0) ? 8'(n_pay) : 8'($urandom));
            repeat (n_pay) frame_bytes.push_back(8'($urandom));
        end
        send_frame();
    endtask

    task automatic test_random_traffic();
        int phase;
        int start_count;
        bit paused;
        logic [7:0] same_id;
        phase = 0;
        start_count = bytes_sent;
        while (bytes_sent - start_count < RANDOM_ITEMS) begin
            wait_drain();
            case (phase % 6)
                0: write_all_regs(8'h00, 8'h00, 8'h00, 1'b1);
                1: write_all_regs(8'hFF, 8'hFF, 8'hFF, 1'b1);
                2: write_all_regs(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
                3: write_all_regs(8'($urandom), 8'($urandom), 8'hFF, 1'b1);
                4: write_all_regs(8'($urandom), 8'($urandom), 8'($urandom),
                                  1'($urandom));
                default: begin
                    same_id = 8'($urandom);
                    write_all_regs(same_id, same_id, 8'($urandom), 1'b1);
                end
            endcase
            // writes outside the register map must be ignored
            write_reg(CFG_W'($urandom_range(4, 255)), 8'($urandom));
            quiet_in  = ($urandom_range(0, 3) == 0);
            quiet_out = ($urandom_range(0, 3) == 0);
            paused = 1'b0;
            while (bytes_sent - start_count < (phase + 1) * PHASE_ITEMS &&
                   bytes_sent - start_count < RANDOM_ITEMS) begin
                random_frame();
                if (!paused && (phase % 3 == 1) &&
                    bytes_sent - start_count >= phase * PHASE_ITEMS + PHASE_ITEMS / 2) begin
                    wait_drain();
                    paused = 1'b1;
                end
            end
            phase++;
        end
        wait_drain();
    endtask

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        out_ready   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        error_count = 0;
        bytes_sent  = 0;
        quiet_in    = 1'b0;
        quiet_out   = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_config();
        test_short_frames();
        test_both_mismatch();
        test_filter_disabled();
        test_long_payload();
        test_random_traffic();

        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("rx_frame_address_filter_tb passed");
        end else begin
            $display("rx_frame_address_filter_tb failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout waiting for transfers");
        $display("rx_frame_address_filter_tb failed");
        $finish;
    end

endmodule
